// File: hdl/ppb_pkg.sv
package ppb_pkg;

    localparam int ADDR_MAX_BITS = 24;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_GET   = 2'd1;
    localparam logic [1:0] OP_BLEND = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_UNSUPP = 2'd2;

    localparam logic [2:0] CFG_SURF_W  = 3'd0;
    localparam logic [2:0] CFG_SURF_H  = 3'd1;
    localparam logic [2:0] CFG_PITCH   = 3'd2;
    localparam logic [2:0] CFG_BPP     = 3'd3;
    localparam logic [2:0] CFG_CLIP_OR = 3'd4;
    localparam logic [2:0] CFG_CLIP_SZ = 3'd5;
    localparam logic [2:0] CFG_LAYOUT  = 3'd6;

    localparam int CFG_DATA_W = 36;

    typedef struct packed {
        logic [12:0] surf_w;
        logic [12:0] surf_h;
        logic [14:0] pitch;
        logic [2:0]  bpp;
        logic [23:0] clip_org;
        logic [25:0] clip_sz;
        logic [35:0] layout;
    } t_cfg;

    typedef struct packed {
        logic [1:0]               status;
        logic [1:0]               op;
        logic [ADDR_MAX_BITS-1:0] addr;
        logic [31:0]              color;
        logic [7:0]               alpha;
        logic [2:0]               bpp;
    } t_job;

    // old + floor((new - old) * a / 256)
    function automatic logic [31:0] f_blend(input logic [31:0] o, input logic [31:0] n,
                                            input logic [7:0] a);
        logic signed [32:0] d;
        logic signed [41:0] p;
        logic signed [41:0] s;
        d = $signed({1'b0, n}) - $signed({1'b0, o});
        p = d * $signed({1'b0, a});
        s = $signed({10'b0, o}) + (p >>> 8);
        return s[31:0];
    endfunction

    function automatic logic [31:0] f_mask(input logic [3:0] w, input logic [4:0] sh);
        logic [63:0] m;
        m = {32'b0, (32'd1 << w) - 32'd1} << sh;
        return m[31:0];
    endfunction

endpackage

// File: hdl/ppb_in_if.sv
interface ppb_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic [31:0] color_in;
    logic [7:0]  alpha;
    modport source (output valid, op, x_pos, y_pos, color_in, alpha, input ready);
    modport sink (input valid, op, x_pos, y_pos, color_in, alpha, output ready);
endinterface

// File: hdl/ppb_out_if.sv
interface ppb_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_color;
    logic [1:0]  status;
    modport source (output valid, read_color, status, input ready);
    modport sink (input valid, read_color, status, output ready);
endinterface

// File: hdl/pixel_put_get_blend_engine_top.sv
// Path: an accepted item passes the input register, is classified into the queue,
//   then goes through memory read and through combine and write.
// Pacing: the back end pops a new item only after it has finished the last one's
//   read then write pass over the four byte banks of the frame memory.
// Reset: synchronous, active low; clears handshakes, queue and configuration
//   registers to their defaults. Frame memory is not cleared.
module pixel_put_get_blend_engine_top
    import ppb_pkg::*;
#(
    parameter int MEM_ADDR_BITS = 18,
    parameter int COORD_BITS    = 12
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ppb_in_if.sink    i_in,
    ppb_out_if.source o_out,
    input  logic                  i_cfg_wr_en,
    input  logic [2:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);
    t_cfg r_cfg;
    logic push, pop, full, empty;
    t_job job_in, job_out;

    // Hold configuration; the user must write it only while no item is in flight, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.surf_w   <= 13'd320;
            r_cfg.surf_h   <= 13'd240;
            r_cfg.pitch    <= 15'd640;
            r_cfg.bpp      <= 3'd2;
            r_cfg.clip_org <= 24'd0;
            r_cfg.clip_sz  <= 26'd1966400;
            r_cfg.layout   <= 36'd1448083627;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_SURF_W:  r_cfg.surf_w   <= i_cfg_wdata[12:0];
                CFG_SURF_H:  r_cfg.surf_h   <= i_cfg_wdata[12:0];
                CFG_PITCH:   r_cfg.pitch    <= i_cfg_wdata[14:0];
                CFG_BPP:     r_cfg.bpp      <= i_cfg_wdata[2:0];
                CFG_CLIP_OR: r_cfg.clip_org <= i_cfg_wdata[23:0];
                CFG_CLIP_SZ: r_cfg.clip_sz  <= i_cfg_wdata[25:0];
                CFG_LAYOUT:  r_cfg.layout   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Front: take the item, check clip, bounds, pixel size and memory, form the byte address
    ppb_front #(.MEM_ADDR_BITS(MEM_ADDR_BITS), .COORD_BITS(COORD_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in), .i_cfg(r_cfg),
        .i_full(full), .o_push(push), .o_job(job_in)
    );

    // Two-entry queue decouples classification from memory work
    ppb_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_job(job_in), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_job(job_out)
    );

    // Back: read the pixel bytes, combine, write back and deliver the result
    ppb_back #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_job(job_out), .o_pop(pop),
        .i_layout(r_cfg.layout), .o_out(o_out)
    );
endmodule

// File: hdl/ppb_fifo.sv
module ppb_fifo
    import ppb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);
    t_job       r_slot [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_job;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

// File: hdl/ppb_front.sv
module ppb_front
    import ppb_pkg::*;
#(
    parameter int MEM_ADDR_BITS = 18,
    parameter int COORD_BITS    = 12
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ppb_in_if.sink i_in,
    input  t_cfg i_cfg,
    input  logic i_full,
    output logic o_push,
    output t_job o_job
);
    logic        r_v;
    logic [1:0]  r_op;
    logic [15:0] r_x, r_y;
    logic [31:0] r_color;
    logic [7:0]  r_alpha;

    logic [31:0] org, sz;
    logic [COORD_BITS-1:0] cx, cy;
    logic [COORD_BITS:0]   cw, ch;
    logic [COORD_BITS+1:0] cx_end, cy_end;
    logic [14:0] xu, yu;
    logic        rej;
    logic [30:0] addr;
    logic [1:0]  maxoff;
    logic [31:0] last;
    logic        mem_rej;
    logic [4:0]  sh;

    assign o_push     = r_v && !i_full;
    assign i_in.ready = !r_v || !i_full;

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op    <= i_in.op;
            r_x     <= i_in.x_pos;
            r_y     <= i_in.y_pos;
            r_color <= i_in.color_in;
            r_alpha <= i_in.alpha;
        end
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_in.ready) begin
            r_v <= i_in.valid;
        end
    end

    always_comb begin
        org    = {8'b0, i_cfg.clip_org};
        sz     = {6'b0, i_cfg.clip_sz};
        cx     = org[COORD_BITS-1:0];
        cy     = org[2*COORD_BITS-1:COORD_BITS];
        cw     = sz[COORD_BITS:0];
        ch     = sz[2*COORD_BITS+1:COORD_BITS+1];
        cx_end = (COORD_BITS+2)'(cx) + (COORD_BITS+2)'(cw);
        cy_end = (COORD_BITS+2)'(cy) + (COORD_BITS+2)'(ch);
        xu     = r_x[14:0];
        yu     = r_y[14:0];
        rej = r_x[15] || r_y[15]
            || (xu < 15'(cx)) || (16'(xu) >= 16'(cx_end))
            || (yu < 15'(cy)) || (16'(yu) >= 16'(cy_end))
            || (xu >= 15'(i_cfg.surf_w)) || (yu >= 15'(i_cfg.surf_h))
            || (i_cfg.bpp == 3'd0) || (i_cfg.bpp > 3'd4);
        addr = 31'(yu * i_cfg.pitch) + 31'(xu * i_cfg.bpp);
        // Three-byte pixels may place a channel in lane three
        maxoff = 2'd2;
        if (i_cfg.bpp == 3'd3) begin
            for (int c = 0; c < 4; c++) begin
                sh = i_cfg.layout[5*c +: 5];
                if (sh[4:3] > maxoff) maxoff = sh[4:3];
            end
        end else begin
            maxoff = 2'(i_cfg.bpp - 3'd1);
        end
        sh      = 5'd0;
        last    = 32'(addr) + 32'(maxoff);
        mem_rej = (last >> MEM_ADDR_BITS) != 32'd0;

        o_job.op    = r_op;
        o_job.addr  = ADDR_MAX_BITS'(addr);
        o_job.color = r_color;
        o_job.alpha = r_alpha;
        o_job.bpp   = i_cfg.bpp;
        if (r_op == OP_NOP) o_job.status = ST_DONE;
        else if (rej || mem_rej) o_job.status = ST_REJECT;
        else if (r_op == OP_BLEND && i_cfg.bpp == 3'd1) o_job.status = ST_UNSUPP;
        else o_job.status = ST_DONE;
    end
endmodule

// File: hdl/ppb_back.sv
module ppb_back
    import ppb_pkg::*;
#(
    parameter int MEM_ADDR_BITS = 18
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  t_job i_job,
    output logic o_pop,
    input  logic [35:0] i_layout,
    ppb_out_if.source o_out
);
    localparam int ROW_BITS = MEM_ADDR_BITS - 2;
    localparam logic S_IDLE = 1'b0;
    localparam logic S_CALC = 1'b1;

    logic [7:0] r_mem [4][2**ROW_BITS];
    logic [7:0] r_rdata [4];
    logic       r_state;
    t_job       r_job;
    logic        r_out_v;
    logic [31:0] r_rd;
    logic [1:0]  r_status;

    logic [MEM_ADDR_BITS-1:0] ra, wa;
    logic [MEM_ADDR_BITS:0]   tmp;
    logic [ROW_BITS-1:0] rrow [4];
    logic [ROW_BITS-1:0] wrow [4];
    logic [7:0] wbank [4];
    logic [3:0] webank;
    logic [7:0] old [4];
    logic [7:0] wbyte [4];
    logic [3:0] wen;
    logic [31:0] rd, oldv, newv, m;
    logic [4:0]  sh [4];
    logic [3:0]  wd [4];
    logic [1:0]  ln;
    logic        go, active;

    assign o_pop       = (r_state == S_IDLE) && !i_empty;
    assign go          = (r_state == S_CALC) && (!r_out_v || o_out.ready);
    assign o_out.valid = r_out_v;
    assign o_out.read_color = r_rd;
    assign o_out.status     = r_status;

    always_comb begin
        ra = i_job.addr[MEM_ADDR_BITS-1:0];
        wa = r_job.addr[MEM_ADDR_BITS-1:0];
        for (int b = 0; b < 4; b++) begin
            tmp     = (MEM_ADDR_BITS+1)'(ra) + (MEM_ADDR_BITS+1)'(2'(2'(b) - ra[1:0]));
            rrow[b] = tmp[MEM_ADDR_BITS-1:2];
            tmp     = (MEM_ADDR_BITS+1)'(wa) + (MEM_ADDR_BITS+1)'(2'(2'(b) - wa[1:0]));
            wrow[b] = tmp[MEM_ADDR_BITS-1:2];
        end
        for (int k = 0; k < 4; k++) begin
            old[k] = r_rdata[2'(wa[1:0] + 2'(k))];
        end
        for (int c = 0; c < 4; c++) begin
            sh[c] = i_layout[5*c +: 5];
            wd[c] = i_layout[20 + 4*c +: 4];
        end
        active = (r_job.status == ST_DONE) && (r_job.op != OP_NOP);
        rd     = 32'd0;
        newv   = 32'd0;
        oldv   = 32'd0;
        m      = 32'd0;
        ln     = 2'd0;
        for (int k = 0; k < 4; k++) begin
            wbyte[k] = 8'd0;
            wen[k]   = 1'b0;
        end
        if (r_job.bpp == 3'd3) begin
            // one byte per channel, later channel wins a shared lane
            for (int c = 0; c < 4; c++) begin
                ln = sh[c][4:3];
                if (r_job.op == OP_GET) begin
                    rd = rd | (32'(old[ln]) << sh[c]);
                end else if (r_job.op == OP_PUT) begin
                    wen[ln]   = 1'b1;
                    wbyte[ln] = 8'(r_job.color >> sh[c]);
                end else if (c < 3 || wd[3] != 4'd0) begin
                    wen[ln]   = 1'b1;
                    wbyte[ln] = 8'(f_blend(32'(old[ln]), 32'(8'(r_job.color >> sh[c])),
                                           r_job.alpha));
                end
            end
        end else begin
            for (int k = 0; k < 4; k++) begin
                if (3'(k) < r_job.bpp) oldv[8*k +: 8] = old[k];
            end
            if (r_job.op == OP_GET) begin
                rd = oldv;
            end else begin
                if (r_job.op == OP_PUT) begin
                    newv = r_job.color;
                end else begin
                    for (int c = 0; c < 4; c++) begin
                        m = f_mask(wd[c], sh[c]);
                        if (c < 3 || wd[3] != 4'd0) begin
                            newv = newv | (f_blend(oldv & m, r_job.color & m, r_job.alpha) & m);
                        end
                    end
                end
                for (int k = 0; k < 4; k++) begin
                    wen[k]   = 3'(k) < r_job.bpp;
                    wbyte[k] = newv[8*k +: 8];
                end
            end
        end
        if (!active) begin
            rd  = 32'd0;
            wen = 4'd0;
        end
        for (int b = 0; b < 4; b++) begin
            webank[b] = go && wen[2'(2'(b) - wa[1:0])];
            wbank[b]  = wbyte[2'(2'(b) - wa[1:0])];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < 4; b++) begin
            if (webank[b]) r_mem[b][wrow[b]] <= wbank[b];
            // hold the read bytes while the result waits
            if (o_pop) r_rdata[b] <= r_mem[b][rrow[b]];
        end
        if (o_pop) r_job <= i_job;
        if (go) begin
            r_rd     <= rd;
            r_status <= r_job.status;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (o_pop) r_state <= S_CALC;
                S_CALC: if (go) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
            if (go) r_out_v <= 1'b1;
            else if (o_out.ready) r_out_v <= 1'b0;
        end
    end
endmodule

// File: hdl/ppb_checker.sv
module ppb_checker
    import ppb_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_read_color,
    input logic [1:0]  i_status
);
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_DONE || i_status == ST_REJECT ||
                         i_status == ST_UNSUPP))
        else $error("status code out of range");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status != ST_DONE) |-> (i_read_color == 32'd0))
        else $error("rejected item carries data");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_read_color)))
        else $error("stalled result dropped or changed");
endmodule

bind pixel_put_get_blend_engine_top ppb_checker u_ppb_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready), .i_read_color(o_out.read_color), .i_status(o_out.status)
);
